[rtl/core/cbor_tsp_pkg.sv]
// Shared types and constants of the CBOR token stream parser.
`timescale 1ns / 1ps

package cbor_tsp_pkg;

	localparam logic [4:0] AI_LITERAL_MAX = 5'd23;
	localparam logic [4:0] AI_ARG_LAST    = 5'd27;
	localparam logic [4:0] AI_INDEFINITE  = 5'd31;
	localparam logic [7:0] BREAK_BYTE     = 8'hFF;

	localparam logic [2:0] MAJ_UINT  = 3'd0;
	localparam logic [2:0] MAJ_NINT  = 3'd1;
	localparam logic [2:0] MAJ_BSTR  = 3'd2;
	localparam logic [2:0] MAJ_TSTR  = 3'd3;
	localparam logic [2:0] MAJ_ARRAY = 3'd4;
	localparam logic [2:0] MAJ_MAP   = 3'd5;
	localparam logic [2:0] MAJ_TAG   = 3'd6;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		TK_INT = 3'd0,
		TK_STR = 3'd1,
		TK_ARR = 3'd2,
		TK_MAP = 3'd3,
		TK_BRK = 3'd4,
		TK_PAY = 3'd5,
		TK_END = 3'd6,
		TK_ERR = 3'd7
	} token_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_RESERVED    = 3'd1,
		ERR_INDEF_INT   = 3'd2,
		ERR_TRUNC       = 3'd3,
		ERR_TOO_LARGE   = 3'd4,
		ERR_UNSUPPORTED = 3'd5
	} err_code_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ARG     = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef struct packed {
		token_kind_t kind;
		logic [63:0] value;
		err_code_t   err;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    res0_v;
		result_t res0;
		logic    res1_v;
		result_t res1;
	} decode_out_t;

	typedef struct packed {
		result_t res;
		phase_t  ph;
		logic    load_pay;
	} head_t;

endpackage

[rtl/core/cbor_tsp_decode.sv]
// Per-byte CBOR decoder: parser state registers and the result logic for one byte.
`timescale 1ns / 1ps

module cbor_tsp_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [7:0]                byte_in,
	input  logic                      last_in,
	output cbor_tsp_pkg::decode_out_t dout
);
	import cbor_tsp_pkg::*;

	phase_t      phase_q;
	logic [2:0]  pend_major_q;
	logic [3:0]  arg_left_q;
	logic [63:0] arg_acc_q;
	logic [62:0] pay_left_q;

	phase_t      phase_d;
	logic [2:0]  pend_major_d;
	logic [3:0]  arg_left_d;
	logic [63:0] arg_acc_d;
	logic [62:0] pay_left_d;

	function automatic result_t mk_res(token_kind_t kind, logic [63:0] value, err_code_t err);
		result_t r;
		r.kind  = kind;
		r.value = value;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic head_t finish_head(logic [2:0] major, logic [63:0] arg, logic last);
		head_t h;
		h.ph       = PH_IDLE;
		h.load_pay = 1'b0;
		h.res      = mk_res(TK_INT, arg, ERR_NONE);
		if (major > MAJ_MAP) begin
			h.res = mk_res(TK_ERR, '1, ERR_UNSUPPORTED);
			h.ph  = PH_DISCARD;
		end else if (arg[63]) begin
			h.res = mk_res(TK_ERR, '1, ERR_TOO_LARGE);
			h.ph  = PH_DISCARD;
		end else begin
			unique case (major)
				MAJ_UINT: h.res = mk_res(TK_INT, arg, ERR_NONE);
				MAJ_NINT: h.res = mk_res(TK_INT, ~arg, ERR_NONE);
				MAJ_BSTR, MAJ_TSTR: begin
					if (arg == 64'd0) begin
						h.res = mk_res(TK_STR, 64'd0, ERR_NONE);
					end else if (last) begin
						h.res = mk_res(TK_ERR, '1, ERR_TRUNC);
						h.ph  = PH_DISCARD;
					end else begin
						h.res      = mk_res(TK_STR, arg, ERR_NONE);
						h.ph       = PH_PAYLOAD;
						h.load_pay = 1'b1;
					end
				end
				MAJ_ARRAY: h.res = mk_res(TK_ARR, arg, ERR_NONE);
				default:   h.res = mk_res(TK_MAP, arg, ERR_NONE);
			endcase
		end
		return h;
	endfunction

	always_comb begin
		head_t       h;
		logic [2:0]  major;
		logic [4:0]  ai;
		logic [63:0] acc_new;
		logic [3:0]  left_new;
		logic        use_head;

		major    = byte_in[7:5];
		ai       = byte_in[4:0];
		acc_new  = {arg_acc_q[55:0], byte_in};
		left_new = arg_left_q - 4'd1;
		use_head = 1'b0;
		h        = finish_head(major, {59'd0, ai}, last_in);

		phase_d      = phase_q;
		pend_major_d = pend_major_q;
		arg_left_d   = arg_left_q;
		arg_acc_d    = arg_acc_q;
		pay_left_d   = pay_left_q;

		dout.res0_v = 1'b0;
		dout.res0   = mk_res(TK_ERR, '1, ERR_NONE);

		unique case (phase_q)
			PH_IDLE: begin
				if (major >= MAJ_TAG) begin
					dout.res0_v = 1'b1;
					if (byte_in == BREAK_BYTE) begin
						dout.res0 = mk_res(TK_BRK, '1, ERR_NONE);
					end else begin
						dout.res0 = mk_res(TK_ERR, '1, ERR_UNSUPPORTED);
						phase_d   = PH_DISCARD;
					end
				end else if (ai <= AI_LITERAL_MAX) begin
					use_head = 1'b1;
				end else if (ai <= AI_ARG_LAST) begin
					if (last_in) begin
						dout.res0_v = 1'b1;
						dout.res0   = mk_res(TK_ERR, '1, ERR_TRUNC);
						phase_d     = PH_DISCARD;
					end else begin
						phase_d      = PH_ARG;
						pend_major_d = major;
						arg_left_d   = 4'd1 << ai[1:0];
						arg_acc_d    = 64'd0;
					end
				end else if (ai == AI_INDEFINITE) begin
					dout.res0_v = 1'b1;
					if (major <= MAJ_NINT) begin
						dout.res0 = mk_res(TK_ERR, '1, ERR_INDEF_INT);
						phase_d   = PH_DISCARD;
					end else if (major <= MAJ_TSTR) begin
						dout.res0 = mk_res(TK_STR, '1, ERR_NONE);
					end else if (major == MAJ_ARRAY) begin
						dout.res0 = mk_res(TK_ARR, '1, ERR_NONE);
					end else begin
						dout.res0 = mk_res(TK_MAP, '1, ERR_NONE);
					end
				end else begin
					dout.res0_v = 1'b1;
					dout.res0   = mk_res(TK_ERR, '1, ERR_RESERVED);
					phase_d     = PH_DISCARD;
				end
			end
			PH_ARG: begin
				arg_acc_d  = acc_new;
				arg_left_d = left_new;
				if (left_new == 4'd0) begin
					h        = finish_head(pend_major_q, acc_new, last_in);
					use_head = 1'b1;
				end else if (last_in) begin
					dout.res0_v = 1'b1;
					dout.res0   = mk_res(TK_ERR, '1, ERR_TRUNC);
					phase_d     = PH_DISCARD;
				end
			end
			PH_PAYLOAD: begin
				dout.res0_v = 1'b1;
				if (last_in && (pay_left_q > 63'd1)) begin
					dout.res0 = mk_res(TK_ERR, '1, ERR_TRUNC);
					phase_d   = PH_DISCARD;
				end else begin
					dout.res0  = mk_res(TK_PAY, {56'd0, byte_in}, ERR_NONE);
					pay_left_d = pay_left_q - 63'd1;
					if (pay_left_q == 63'd1) begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase

		if (use_head) begin
			dout.res0_v = 1'b1;
			dout.res0   = h.res;
			phase_d     = h.ph;
			if (h.load_pay) begin
				pay_left_d = h.res.value[62:0];
			end
		end

		dout.res0.last = ~last_in;
		dout.res1_v    = last_in;
		dout.res1      = mk_res(TK_END, '1, ERR_NONE);
		dout.res1.last = 1'b1;

		if (last_in) begin
			phase_d      = PH_IDLE;
			pend_major_d = 3'd0;
			arg_left_d   = 4'd0;
			arg_acc_d    = 64'd0;
			pay_left_d   = 63'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pend_major_q <= 3'd0;
			arg_left_q   <= 4'd0;
			arg_acc_q    <= 64'd0;
			pay_left_q   <= 63'd0;
		end else if (fire) begin
			phase_q      <= phase_d;
			pend_major_q <= pend_major_d;
			arg_left_q   <= arg_left_d;
			arg_acc_q    <= arg_acc_d;
			pay_left_q   <= pay_left_d;
		end
	end

endmodule

[rtl/core/cbor_tsp_outq.sv]
// Result queue that takes up to two results per byte and hands out one per transfer.
`timescale 1ns / 1ps

module cbor_tsp_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  cbor_tsp_pkg::decode_out_t din,
	output logic                      room,
	output logic                      out_valid,
	input  logic                      out_stall,
	output cbor_tsp_pkg::result_t     head
);
	import cbor_tsp_pkg::*;

	result_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic [Q_CNT_W-1:0]   push_n;
	logic                 pop;

	assign push_n    = push ? (Q_CNT_W'(din.res0_v) + Q_CNT_W'(din.res1_v)) : '0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			if (din.res0_v) begin
				entry_q[wr_ptr_q] <= din.res0;
			end
			if (din.res1_v) begin
				entry_q[wr_ptr_q + Q_PTR_W'(din.res0_v)] <= din.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[Q_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + push_n - Q_CNT_W'(pop);
		end
	end

endmodule

[rtl/core/cbor_token_stream_parser.sv]
// Top level of the CBOR token stream parser: input register, decoder and result queue.
// The parser takes an encoded CBOR buffer one byte per transfer on the data channel
// (data_byte, last_byte flags the final byte) and returns tokens on the token channel
// (token_kind, token_value, error_code, last_of_run). Each byte yields zero, one or
// two tokens; last_of_run marks the final token caused by a byte, and the last byte
// of a buffer is always followed by an end-of-data token.
// An accepted byte is held in the input register, decoded by combinational logic
// and written into the result queue, whose head drives the token channel.
// Throughput: one byte per cycle while the result queue has room. A byte is decoded
// once the four-entry result queue has space for two tokens; only bytes that make
// two tokens (final bytes) need a second transfer on the output channel.
// When the token receiver stalls, the queue fills and data_stall rises; no token
// is lost or reordered. Asynchronous reset returns the parser to the idle state
// awaiting an item head and empties the input register and the queue.
`timescale 1ns / 1ps

module cbor_token_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	output logic               data_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               token_valid,
	input  logic               token_stall,
	output logic [2:0]         token_kind,
	output logic signed [63:0] token_value,
	output logic [2:0]         error_code,
	output logic               last_of_run
);
	import cbor_tsp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        room;
	logic        fire;
	decode_out_t dec;
	result_t     head;

	assign fire       = valid_s1 && room;
	assign data_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	cbor_tsp_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.dout    (dec)
	);

	cbor_tsp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.din       (dec),
		.room      (room),
		.out_valid (token_valid),
		.out_stall (token_stall),
		.head      (head)
	);

	assign token_kind  = head.kind;
	assign token_value = $signed(head.value);
	assign error_code  = head.err;
	assign last_of_run = head.last;

endmodule

[sim/cbor_token_stream_parser_checker.sv]
// Checker that predicts the token stream of the CBOR token stream parser and compares it.
`timescale 1ns / 1ps

module cbor_token_stream_parser_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	input  logic               data_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	input  logic               token_valid,
	input  logic               token_stall,
	input  logic [2:0]         token_kind,
	input  logic signed [63:0] token_value,
	input  logic [2:0]         error_code,
	input  logic               last_of_run,
	output int                 fail_count,
	output int                 tokens_owed
);
	import cbor_tsp_pkg::*;

	phase_t      ph;
	logic [2:0]  pend_maj;
	logic [3:0]  arg_left;
	logic [63:0] arg_acc;
	logic [62:0] pay_left;

	result_t byte_tokens[$];
	result_t owed_tokens[$];

	int n_fail = 0;
	int n_owed = 0;

	assign fail_count = n_fail;
	assign tokens_owed = n_owed;

	function automatic void clear_state();
		ph = PH_IDLE;
		pend_maj = MAJ_UINT;
		arg_left = '0;
		arg_acc = '0;
		pay_left = '0;
	endfunction

	function automatic void emit(token_kind_t k, logic [63:0] v, err_code_t e);
		result_t r;
		if (byte_tokens.size() < 2) begin
			r.kind = k;
			r.value = v;
			r.err = e;
			r.last = 1'b0;
			byte_tokens.push_back(r);
		end
	endfunction

	function automatic void raise_error(err_code_t e);
		emit(TK_ERR, '1, e);
		ph = PH_DISCARD;
	endfunction

	function automatic void close_head(logic [2:0] mj, logic [63:0] arg, logic fin);
		ph = PH_IDLE;
		if (mj > MAJ_MAP) begin
			raise_error(ERR_UNSUPPORTED);
		end else if (arg[63]) begin
			raise_error(ERR_TOO_LARGE);
		end else begin
			case (mj)
				MAJ_UINT: emit(TK_INT, arg, ERR_NONE);
				MAJ_NINT: emit(TK_INT, ~arg, ERR_NONE);
				MAJ_BSTR, MAJ_TSTR: begin
					if (arg == 64'd0) begin
						emit(TK_STR, 64'd0, ERR_NONE);
					end else if (fin) begin
						raise_error(ERR_TRUNC);
					end else begin
						emit(TK_STR, arg, ERR_NONE);
						ph = PH_PAYLOAD;
						pay_left = arg[62:0];
					end
				end
				MAJ_ARRAY: emit(TK_ARR, arg, ERR_NONE);
				default: emit(TK_MAP, arg, ERR_NONE);
			endcase
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic fin);
		logic [2:0] mj;
		logic [4:0] ai;
		result_t r;
		mj = b[7:5];
		ai = b[4:0];
		byte_tokens.delete();
		case (ph)
			PH_IDLE: begin
				if (mj >= MAJ_TAG) begin
					if (b == BREAK_BYTE) emit(TK_BRK, '1, ERR_NONE);
					else raise_error(ERR_UNSUPPORTED);
				end else if (ai <= AI_LITERAL_MAX) begin
					close_head(mj, {59'd0, ai}, fin);
				end else if (ai <= AI_ARG_LAST) begin
					if (fin) begin
						raise_error(ERR_TRUNC);
					end else begin
						ph = PH_ARG;
						pend_maj = mj;
						arg_left = 4'd1 << ai[1:0];
						arg_acc = '0;
					end
				end else if (ai == AI_INDEFINITE) begin
					if (mj <= MAJ_NINT) raise_error(ERR_INDEF_INT);
					else if (mj <= MAJ_TSTR) emit(TK_STR, '1, ERR_NONE);
					else if (mj == MAJ_ARRAY) emit(TK_ARR, '1, ERR_NONE);
					else emit(TK_MAP, '1, ERR_NONE);
				end else begin
					raise_error(ERR_RESERVED);
				end
			end
			PH_ARG: begin
				arg_acc = {arg_acc[55:0], b};
				arg_left = arg_left - 4'd1;
				if (arg_left == 4'd0) close_head(pend_maj, arg_acc, fin);
				else if (fin) raise_error(ERR_TRUNC);
			end
			PH_PAYLOAD: begin
				if (fin && pay_left > 63'd1) begin
					raise_error(ERR_TRUNC);
				end else begin
					emit(TK_PAY, {56'd0, b}, ERR_NONE);
					pay_left = pay_left - 63'd1;
					if (pay_left == 63'd0) ph = PH_IDLE;
				end
			end
			default: ;
		endcase
		if (fin) begin
			emit(TK_END, '1, ERR_NONE);
			clear_state();
		end
		if (byte_tokens.size() > 0) begin
			r = byte_tokens.pop_back();
			r.last = 1'b1;
			byte_tokens.push_back(r);
		end
		foreach (byte_tokens[i]) owed_tokens.push_back(byte_tokens[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_state();
			owed_tokens.delete();
			n_owed = 0;
		end else begin
			if (token_valid && !token_stall) begin
				if (owed_tokens.size() == 0) begin
					$error("unexpected token: kind %0d, value %h", token_kind, token_value);
					n_fail++;
				end else begin
					want = owed_tokens.pop_front();
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
						n_fail++;
					end
					if (token_value !== want.value) begin
						$error("token_value: expected %h, actual %h", want.value, token_value);
						n_fail++;
					end
					if (error_code !== want.err) begin
						$error("error_code: expected %0d, actual %0d", want.err, error_code);
						n_fail++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
						n_fail++;
					end
				end
			end
			if (data_valid && !data_stall) decode_byte(data_byte, last_byte);
			n_owed = owed_tokens.size();
		end
	end

endmodule

[sim/cbor_token_stream_parser_tb.sv]
// Testbench top of the CBOR token stream parser: clock, reset, byte streams and verdict.
`timescale 1ns / 1ps

module cbor_token_stream_parser_tb;
	import cbor_tsp_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               data_valid;
	logic               data_stall;
	logic [7:0]         data_byte;
	logic               last_byte;
	logic               token_valid;
	logic               token_stall;
	logic [2:0]         token_kind;
	logic signed [63:0] token_value;
	logic [2:0]         error_code;
	logic               last_of_run;
	int                 fail_count;
	int                 tokens_owed;

	int         burst_left = 0;
	int         bytes_sent = 0;
	logic [7:0] stream_q[$];

	localparam logic [8:0] DIRECTED_BYTES [23] = '{
		9'h000, 9'h037, 9'h038, 9'h0FF, 9'h05C, 9'h112,
		9'h11F,
		9'h09F, 9'h07F, 9'h042, 9'h0AA, 9'h055, 9'h060, 9'h080, 9'h0A1, 9'h0FF,
		9'h0C0, 9'h101,
		9'h019, 9'h101,
		9'h043, 9'h101,
		9'h141
	};

	cbor_token_stream_parser u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_value (token_value),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	cbor_token_stream_parser_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_value (token_value),
		.error_code  (error_code),
		.last_of_run (last_of_run),
		.fail_count  (fail_count),
		.tokens_owed (tokens_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("cbor_token_stream_parser regression: fail");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		if (burst_left == 0) begin
			data_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 20);
		end
		burst_left--;
		data_valid = 1'b1;
		data_byte = b;
		last_byte = fin;
		do @(posedge clk); while (data_stall);
		bytes_sent++;
	endtask

	function automatic logic [63:0] rand_arg();
		case ($urandom_range(0, 19))
			0: return 64'($urandom);
			1: return {1'b0, 31'($urandom), 32'($urandom)};
			2: return 64'h7FFF_FFFF_FFFF_FFFF;
			3: return {1'b1, 31'($urandom), 32'($urandom)};
			4: return '1;
			5, 6: return 64'($urandom_range(0, 255));
			7, 8: return 64'($urandom_range(0, 65535));
			default: return 64'($urandom_range(0, 23));
		endcase
	endfunction

	function automatic void push_head(logic [2:0] mj, logic [63:0] arg);
		int kmin;
		int k;
		if (arg <= 64'(AI_LITERAL_MAX) && $urandom_range(0, 3) != 0) begin
			stream_q.push_back({mj, arg[4:0]});
		end else begin
			kmin = (arg[63:32] != 0) ? 3 : (arg[31:16] != 0) ? 2 : (arg[15:8] != 0) ? 1 : 0;
			k = $urandom_range(kmin, 3);
			stream_q.push_back({mj, 5'(AI_ARG_LAST - 3 + k)});
			for (int i = (1 << k) - 1; i >= 0; i--) stream_q.push_back(arg[8 * i +: 8]);
		end
	endfunction

	function automatic void push_string(logic [2:0] mj);
		int len;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
		push_head(mj, 64'(len));
		repeat (len) stream_q.push_back(8'($urandom));
	endfunction

	function automatic void push_item();
		logic [2:0] mj;
		case ($urandom_range(0, 19))
			0, 1, 2: push_head(MAJ_UINT, rand_arg());
			3, 4: push_head(MAJ_NINT, rand_arg());
			5, 6, 7: push_string($urandom_range(0, 1) ? MAJ_TSTR : MAJ_BSTR);
			8: begin
				mj = $urandom_range(0, 1) ? MAJ_TSTR : MAJ_BSTR;
				stream_q.push_back({mj, AI_INDEFINITE});
				repeat ($urandom_range(0, 2)) push_string(mj);
				stream_q.push_back(BREAK_BYTE);
			end
			9: push_head(MAJ_ARRAY, ($urandom_range(0, 3) == 0) ? rand_arg()
				: 64'($urandom_range(0, 10)));
			10: push_head(MAJ_MAP, ($urandom_range(0, 3) == 0) ? rand_arg()
				: 64'($urandom_range(0, 10)));
			11: begin
				stream_q.push_back({$urandom_range(0, 1) ? MAJ_MAP : MAJ_ARRAY, AI_INDEFINITE});
				push_head(MAJ_UINT, 64'($urandom_range(0, 300)));
				stream_q.push_back(BREAK_BYTE);
			end
			12: begin
				case ($urandom_range(0, 2))
					0: stream_q.push_back({3'($urandom_range(0, 5)),
						5'(AI_ARG_LAST + $urandom_range(1, 3))});
					1: stream_q.push_back({$urandom_range(0, 1) ? MAJ_NINT : MAJ_UINT,
						AI_INDEFINITE});
					default: stream_q.push_back(8'($urandom_range({MAJ_TAG, 5'd0},
						BREAK_BYTE - 1)));
				endcase
			end
			13: stream_q.push_back(BREAK_BYTE);
			default: push_head(MAJ_UINT, 64'($urandom_range(0, 1000)));
		endcase
	endfunction

	task automatic send_stream();
		int style;
		int keep;
		stream_q.delete();
		style = $urandom_range(0, 9);
		if (style == 0) begin
			repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) push_item();
			if (style == 1) begin
				keep = $urandom_range(1, stream_q.size());
				while (stream_q.size() > keep) void'(stream_q.pop_back());
			end
		end
		foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
	endtask

	initial begin
		int cyc;
		int mode;
		int mode_left;
		cyc = 0;
		mode = 0;
		mode_left = 0;
		token_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc == 1500) begin
				token_stall = 1'b1;
				repeat (400) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: token_stall = 1'b0;
				1: token_stall = 1'($urandom_range(0, 1));
				2: token_stall = ($urandom_range(0, 3) != 0);
				default: token_stall = (cyc % 3 == 0);
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		data_valid = 1'b0;
		data_byte = 8'd0;
		last_byte = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
		while (bytes_sent < 1750) send_stream();

		@(negedge clk);
		data_valid = 1'b0;
		while (tokens_owed != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("cbor_token_stream_parser regression: pass");
		else
			$display("cbor_token_stream_parser regression: fail");
		$finish;
	end

endmodule
